[src/hshr_pkg.sv]
// Shared types and codes for the hourly sample history ring.
// No dependencies; used by hshr_mem, hourly_sample_history_ring and the testbench.
package hshr_pkg;

	localparam int ENTRIES_DEF = 256;

	localparam int TEMP_W  = 16;
	localparam int HUM_W   = 10;
	localparam int PRESS_W = 16;
	localparam int HELD_W  = 9;
	localparam int DELTA_W = 17;
	localparam int AGE_W   = 16;
	localparam int KIND_W  = 8;
	localparam int HOUR_W  = 16;

	localparam logic [1:0] OP_ADD   = 2'd0;
	localparam logic [1:0] OP_READ  = 2'd1;
	localparam logic [1:0] OP_DELTA = 2'd2;
	localparam logic [1:0] OP_CLEAR = 2'd3;

	localparam logic [KIND_W-1:0] KIND_TEMP  = 8'd1;
	localparam logic [KIND_W-1:0] KIND_PRESS = 8'd2;
	localparam logic [KIND_W-1:0] KIND_HUM   = 8'd3;

	typedef struct packed {
		logic signed [TEMP_W-1:0] temp;
		logic [HUM_W-1:0]         hum;
		logic [PRESS_W-1:0]       press;
	} sample_t;

endpackage

[src/hshr_mem.sv]
// Sample store: one write port, two registered read ports.
// Depends on hshr_pkg (sample_t).
module hshr_mem import hshr_pkg::*; #(
	parameter int DEPTH = ENTRIES_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  sample_t       wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr_a,
	input  logic [AW-1:0] raddr_b,
	output sample_t       rdata_a,
	output sample_t       rdata_b
);

	sample_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_a <= mem[raddr_a];
			rdata_b <= mem[raddr_b];
		end
	end

endmodule

[src/hourly_sample_history_ring.sv]
// Top level of the hourly sample history ring: ring pointers, op decode, result stage.
// Depends on hshr_pkg and hshr_mem.
//
//  channel | signals                                   | transfer when
//  --------+-------------------------------------------+--------------------------
//  in      | op hour_now temp_in hum_in press_in age kind | in_valid && in_ready
//  out     | ok temp_out hum_out press_out delta held     | out_valid && out_ready
//
// An add writes the store at its input transfer; a read or delta reads it there into
// the registered read ports and the read stage, and the output register is loaded from
// them when the read stage moves on, ahead of the output transfer.
// With out_ready high one item per cycle is sustained. A held output keeps the read
// stage and drops in_ready while the read stage is full.
// Reset clears pointer, count, last hour and valid flags; the store is not cleared.
module hourly_sample_history_ring import hshr_pkg::*; #(
	parameter int ENTRIES = ENTRIES_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [1:0]                op,
	input  logic [HOUR_W-1:0]         hour_now,
	input  logic signed [TEMP_W-1:0]  temp_in,
	input  logic [HUM_W-1:0]          hum_in,
	input  logic [PRESS_W-1:0]        press_in,
	input  logic [AGE_W-1:0]          age,
	input  logic [KIND_W-1:0]         kind,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic                      ok,
	output logic signed [TEMP_W-1:0]  temp_out,
	output logic [HUM_W-1:0]          hum_out,
	output logic [PRESS_W-1:0]        press_out,
	output logic signed [DELTA_W-1:0] delta,
	output logic [HELD_W-1:0]         held
);

	localparam int AW = $clog2(ENTRIES);
	localparam int CW = $clog2(ENTRIES + 1);
	localparam logic [AW-1:0] LAST_SLOT = AW'(ENTRIES - 1);
	localparam logic [CW-1:0] FULL_CNT  = CW'(ENTRIES);

	logic [AW-1:0]     newest_q;
	logic [CW-1:0]     count_q;
	logic [HOUR_W-1:0] hour_seen_q;

	logic              v_s1;
	logic [1:0]        op_s1;
	logic              ok_s1;
	logic [KIND_W-1:0] kind_s1;
	logic [HELD_W-1:0] held_s1;

	logic out_free, in_fire, s1_move;

	logic          add_hit, read_hit, delta_hit, mem_re;
	logic [AW-1:0] next_slot, prev_slot, age_slot, age_addr;
	logic [AW-1:0] newest_n;
	logic [CW-1:0] count_n;
	logic          ok_n;
	sample_t       wdata, rd_a, rd_b;

	logic                      ok_r;
	logic signed [TEMP_W-1:0]  temp_r;
	logic [HUM_W-1:0]          hum_r;
	logic [PRESS_W-1:0]        press_r;
	logic signed [DELTA_W-1:0] delta_r;

	assign out_free = !out_valid || out_ready;
	assign s1_move  = v_s1 && out_free;
	assign in_ready = !v_s1 || out_free;
	assign in_fire  = in_valid && in_ready;

	always_comb begin
		next_slot = (newest_q == LAST_SLOT) ? '0 : newest_q + AW'(1);
		prev_slot = (newest_q == '0) ? LAST_SLOT : newest_q - AW'(1);
		age_slot  = AW'(age);
		if (newest_q >= age_slot) begin
			age_addr = newest_q - age_slot;
		end else begin
			age_addr = AW'((ENTRIES + 32'(newest_q)) - 32'(age_slot));
		end
	end

	assign add_hit   = (op == OP_ADD) && (hour_now != hour_seen_q);
	assign read_hit  = (op == OP_READ) && (DELTA_W'(count_q) > {1'b0, age});
	assign delta_hit = (op == OP_DELTA) && (count_q >= CW'(2))
		&& (kind == KIND_TEMP || kind == KIND_PRESS || kind == KIND_HUM);
	assign mem_re    = in_fire && (op == OP_READ || op == OP_DELTA);

	always_comb begin
		newest_n = newest_q;
		count_n  = count_q;
		ok_n     = 1'b0;
		case (op)
			OP_ADD: begin
				if (add_hit) begin
					newest_n = next_slot;
					if (count_q < FULL_CNT) begin
						count_n = count_q + CW'(1);
					end
					ok_n = 1'b1;
				end
			end
			OP_READ:  ok_n = read_hit;
			OP_DELTA: ok_n = delta_hit;
			default: begin
				newest_n = '0;
				count_n  = '0;
				ok_n     = 1'b1;
			end
		endcase
	end

	assign wdata = '{temp: temp_in, hum: hum_in, press: press_in};

	hshr_mem #(
		.DEPTH (ENTRIES),
		.AW    (AW)
	) u_mem (
		.clk     (clk),
		.we      (in_fire && add_hit),
		.waddr   (next_slot),
		.wdata   (wdata),
		.re      (mem_re),
		.raddr_a ((op == OP_READ) ? age_addr : newest_q),
		.raddr_b (prev_slot),
		.rdata_a (rd_a),
		.rdata_b (rd_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			newest_q    <= '0;
			count_q     <= '0;
			hour_seen_q <= '0;
			v_s1        <= 1'b0;
			out_valid   <= 1'b0;
		end else begin
			if (in_fire) begin
				newest_q <= newest_n;
				count_q  <= count_n;
				if (add_hit) begin
					hour_seen_q <= hour_now;
				end
			end
			if (in_fire) begin
				v_s1 <= 1'b1;
			end else if (s1_move) begin
				v_s1 <= 1'b0;
			end
			if (s1_move) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			op_s1   <= op;
			ok_s1   <= ok_n;
			kind_s1 <= kind;
			held_s1 <= HELD_W'(count_n);
		end
	end

	always_comb begin
		ok_r    = ok_s1;
		temp_r  = '0;
		hum_r   = '0;
		press_r = '0;
		delta_r = '0;
		if (ok_s1 && op_s1 == OP_READ) begin
			temp_r  = rd_a.temp;
			hum_r   = rd_a.hum;
			press_r = rd_a.press;
		end
		if (ok_s1 && op_s1 == OP_DELTA) begin
			case (kind_s1)
				KIND_TEMP: delta_r = DELTA_W'($signed(rd_a.temp))
					- DELTA_W'($signed(rd_b.temp));
				KIND_PRESS: delta_r = DELTA_W'({1'b0, rd_a.press})
					- DELTA_W'({1'b0, rd_b.press});
				KIND_HUM: delta_r = DELTA_W'({1'b0, rd_a.hum}) - DELTA_W'({1'b0, rd_b.hum});
				default: delta_r = '0;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			ok        <= ok_r;
			temp_out  <= temp_r;
			hum_out   <= hum_r;
			press_out <= press_r;
			delta     <= delta_r;
			held      <= held_s1;
		end
	end

endmodule

[tb/hshr_tb_pkg.sv]
// Tracker for the hourly sample history ring: mirrors the ring state and checks each result.
// Depends on hshr_pkg for widths and op/kind codes.
package hshr_tb_pkg;
	import hshr_pkg::*;

	typedef struct {
		logic                      ok;
		logic signed [TEMP_W-1:0]  temp;
		logic [HUM_W-1:0]          hum;
		logic [PRESS_W-1:0]        press;
		logic signed [DELTA_W-1:0] delta;
		logic [HELD_W-1:0]         held;
	} ring_answer_t;

	class history_ring_tracker;
		int unsigned newest_slot;
		int unsigned held_count;
		logic [HOUR_W-1:0] hour_seen;
		logic signed [TEMP_W-1:0] temp_mem [ENTRIES_DEF];
		logic [HUM_W-1:0] hum_mem [ENTRIES_DEF];
		logic [PRESS_W-1:0] press_mem [ENTRIES_DEF];
		ring_answer_t pending_answers[$];
		int unsigned mismatches;
		int unsigned checked;
		int unsigned items_seen;
		int unsigned adds_stored;
		int unsigned reads_hit;
		int unsigned deltas_done;
		int unsigned clears_done;

		function new();
			newest_slot = 0;
			held_count = 0;
			hour_seen = '0;
			foreach (temp_mem[i]) begin
				temp_mem[i] = '0;
				hum_mem[i] = '0;
				press_mem[i] = '0;
			end
			mismatches = 0;
			checked = 0;
			items_seen = 0;
			adds_stored = 0;
			reads_hit = 0;
			deltas_done = 0;
			clears_done = 0;
		endfunction

		function int unsigned slot_back(int unsigned back);
			return (newest_slot + ENTRIES_DEF - (back % ENTRIES_DEF)) % ENTRIES_DEF;
		endfunction

		function void note_transfer_in(logic [1:0] op, logic [HOUR_W-1:0] hour,
				logic signed [TEMP_W-1:0] temp, logic [HUM_W-1:0] hum,
				logic [PRESS_W-1:0] press, logic [AGE_W-1:0] age, logic [KIND_W-1:0] kind);
			ring_answer_t ans;
			int unsigned s;
			int unsigned b;
			int d;
			ans.ok = 1'b0;
			ans.temp = '0;
			ans.hum = '0;
			ans.press = '0;
			ans.delta = '0;
			d = 0;
			items_seen++;
			case (op)
				OP_ADD: begin
					if (hour != hour_seen) begin
						hour_seen = hour;
						if (held_count < ENTRIES_DEF)
							held_count++;
						newest_slot = (newest_slot + 1) % ENTRIES_DEF;
						temp_mem[newest_slot] = temp;
						hum_mem[newest_slot] = hum;
						press_mem[newest_slot] = press;
						ans.ok = 1'b1;
						adds_stored++;
					end
				end
				OP_READ: begin
					if (held_count > age) begin
						s = slot_back(age);
						ans.temp = temp_mem[s];
						ans.hum = hum_mem[s];
						ans.press = press_mem[s];
						ans.ok = 1'b1;
						reads_hit++;
					end
				end
				OP_DELTA: begin
					if (held_count >= 2 && (kind == KIND_TEMP || kind == KIND_PRESS ||
							kind == KIND_HUM)) begin
						s = newest_slot;
						b = slot_back(1);
						if (kind == KIND_TEMP)
							d = int'(temp_mem[s]) - int'(temp_mem[b]);
						else if (kind == KIND_PRESS)
							d = int'(press_mem[s]) - int'(press_mem[b]);
						else
							d = int'(hum_mem[s]) - int'(hum_mem[b]);
						ans.ok = 1'b1;
						deltas_done++;
					end
					ans.delta = d[DELTA_W-1:0];
				end
				default: begin
					newest_slot = 0;
					held_count = 0;
					ans.ok = 1'b1;
					clears_done++;
				end
			endcase
			ans.held = held_count[HELD_W-1:0];
			pending_answers.push_back(ans);
		endfunction

		function void check_transfer_out(logic ok, logic signed [TEMP_W-1:0] temp,
				logic [HUM_W-1:0] hum, logic [PRESS_W-1:0] press,
				logic signed [DELTA_W-1:0] delta, logic [HELD_W-1:0] held);
			ring_answer_t want;
			checked++;
			if (pending_answers.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: ok=%0d temp=%0d hum=%0d press=%0d delta=%0d held=%0d",
						ok, temp, hum, press, delta, held);
				return;
			end
			want = pending_answers.pop_front();
			if (want.ok !== ok || want.temp !== temp || want.hum !== hum ||
					want.press !== press || want.delta !== delta || want.held !== held) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("mismatch %0d: expected ok=%0d temp=%0d hum=%0d press=%0d delta=%0d held=%0d",
						mismatches, want.ok, want.temp, want.hum, want.press, want.delta,
						want.held);
					$display("             actual ok=%0d temp=%0d hum=%0d press=%0d delta=%0d held=%0d",
						ok, temp, hum, press, delta, held);
				end
			end
		endfunction
	endclass

endpackage

[tb/tb.sv]
// Testbench top for hourly_sample_history_ring: directed and random op streams with
// random idling on both channels. Depends on hshr_pkg, hshr_tb_pkg and the RTL.
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import hshr_pkg::*;
	import hshr_tb_pkg::*;

	logic                      clk;
	logic                      arst_n;
	logic                      in_valid;
	logic                      in_ready;
	logic [1:0]                op;
	logic [HOUR_W-1:0]         hour_now;
	logic signed [TEMP_W-1:0]  temp_in;
	logic [HUM_W-1:0]          hum_in;
	logic [PRESS_W-1:0]        press_in;
	logic [AGE_W-1:0]          age;
	logic [KIND_W-1:0]         kind;
	logic                      out_valid;
	logic                      out_ready;
	logic                      ok;
	logic signed [TEMP_W-1:0]  temp_out;
	logic [HUM_W-1:0]          hum_out;
	logic [PRESS_W-1:0]        press_out;
	logic signed [DELTA_W-1:0] delta;
	logic [HELD_W-1:0]         held;

	history_ring_tracker ring;
	bit calm;
	logic [HOUR_W-1:0] last_add_hour;

	hourly_sample_history_ring i_dut (.*);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("simulation failed");
		$finish;
	end

	initial begin
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			out_ready <= calm || ($urandom_range(99) >= 14);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			ring.check_transfer_out(ok, temp_out, hum_out, press_out, delta, held);
	end

	task automatic send_item(input logic [1:0] o, input logic [HOUR_W-1:0] hr,
			input logic signed [TEMP_W-1:0] t, input logic [HUM_W-1:0] h,
			input logic [PRESS_W-1:0] p, input logic [AGE_W-1:0] a,
			input logic [KIND_W-1:0] k);
		while (!calm && $urandom_range(99) < 14) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		op <= o;
		hour_now <= hr;
		temp_in <= t;
		hum_in <= h;
		press_in <= p;
		age <= a;
		kind <= k;
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		ring.note_transfer_in(o, hr, t, h, p, a, k);
		if (o == OP_ADD)
			last_add_hour = hr;
	endtask

	task automatic send_random(input bit allow_clear);
		int unsigned pick;
		int unsigned cnt;
		logic [1:0] o;
		logic [HOUR_W-1:0] hr;
		logic signed [TEMP_W-1:0] t;
		logic [HUM_W-1:0] h;
		logic [PRESS_W-1:0] p;
		logic [AGE_W-1:0] a;
		logic [KIND_W-1:0] k;
		pick = $urandom_range(99);
		cnt = ring.held_count;
		t = TEMP_W'($urandom);
		p = PRESS_W'($urandom);
		hr = HOUR_W'($urandom);
		a = AGE_W'($urandom);
		k = KIND_W'($urandom);
		if ($urandom_range(19) == 0)
			h = HUM_W'($urandom);
		else
			h = HUM_W'($urandom_range(1000));
		if (pick < 50) begin
			o = OP_ADD;
			case ($urandom_range(9))
				0: hr = last_add_hour;
				1: hr = HOUR_W'($urandom);
				default: hr = last_add_hour + HOUR_W'($urandom_range(3, 1));
			endcase
		end else if (pick < 70) begin
			o = OP_READ;
			case ($urandom_range(9))
				0: a = AGE_W'($urandom);
				1, 2: a = AGE_W'(cnt + $urandom_range(2));
				default: a = (cnt == 0) ? '0 : AGE_W'($urandom_range(cnt - 1));
			endcase
		end else if (pick < 90) begin
			o = OP_DELTA;
			if ($urandom_range(4) != 0)
				k = KIND_W'($urandom_range(3));
		end else if (pick < 92) begin
			o = allow_clear ? OP_CLEAR : OP_ADD;
		end else begin
			o = 2'($urandom);
			if (o == OP_CLEAR && !allow_clear)
				o = OP_READ;
		end
		send_item(o, hr, t, h, p, a, k);
	endtask

	initial begin
		ring = new();
		calm = 1'b0;
		last_add_hour = '0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		op = OP_ADD;
		hour_now = '0;
		temp_in = '0;
		hum_in = '0;
		press_in = '0;
		age = '0;
		kind = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// hour 0 right after reset counts as repeated
		send_item(OP_ADD, 16'd0, 16'sd1234, 10'd500, 16'd10000, 16'd0, 8'd0);
		send_item(OP_READ, 16'd0, 16'sd0, 10'd0, 16'd0, 16'd0, 8'd0);
		send_item(OP_DELTA, 16'd0, 16'sd0, 10'd0, 16'd0, 16'd0, KIND_TEMP);
		send_item(OP_ADD, 16'd1, -16'sd32768, 10'd0, 16'd0, 16'd0, 8'd0);
		send_item(OP_ADD, 16'd1, 16'sd5, 10'd5, 16'd5, 16'd0, 8'd0);
		send_item(OP_DELTA, 16'd0, 16'sd0, 10'd0, 16'd0, 16'd0, KIND_TEMP);
		send_item(OP_READ, 16'd0, 16'sd0, 10'd0, 16'd0, 16'd0, 8'd0);
		send_item(OP_READ, 16'd0, 16'sd0, 10'd0, 16'd0, 16'd1, 8'd0);
		send_item(OP_ADD, 16'd2, 16'sd32767, 10'd1023, 16'd65535, 16'd0, 8'd0);
		send_item(OP_DELTA, 16'd0, 16'sd0, 10'd0, 16'd0, 16'd0, KIND_TEMP);
		send_item(OP_DELTA, 16'd0, 16'sd0, 10'd0, 16'd0, 16'd0, KIND_PRESS);
		send_item(OP_DELTA, 16'd0, 16'sd0, 10'd0, 16'd0, 16'd0, KIND_HUM);
		send_item(OP_DELTA, 16'd0, 16'sd0, 10'd0, 16'd0, 16'd0, 8'd0);
		send_item(OP_DELTA, 16'd0, 16'sd0, 10'd0, 16'd0, 16'd0, 8'd4);
		send_item(OP_DELTA, 16'd0, 16'sd0, 10'd0, 16'd0, 16'd0, 8'hFF);
		send_item(OP_ADD, 16'hFFFF, -16'sd32768, 10'd0, 16'd0, 16'd0, 8'd0);
		send_item(OP_DELTA, 16'd0, 16'sd0, 10'd0, 16'd0, 16'd0, KIND_TEMP);
		send_item(OP_DELTA, 16'd0, 16'sd0, 10'd0, 16'd0, 16'd0, KIND_PRESS);
		send_item(OP_DELTA, 16'd0, 16'sd0, 10'd0, 16'd0, 16'd0, KIND_HUM);
		send_item(OP_READ, 16'd0, 16'sd0, 10'd0, 16'd0, 16'd2, 8'd0);
		send_item(OP_READ, 16'd0, 16'sd0, 10'd0, 16'd0, 16'd3, 8'd0);
		send_item(OP_READ, 16'd0, 16'sd0, 10'd0, 16'd0, 16'hFFFF, 8'd0);
		send_item(OP_CLEAR, 16'd0, 16'sd0, 10'd0, 16'd0, 16'd0, 8'd0);
		send_item(OP_READ, 16'd0, 16'sd0, 10'd0, 16'd0, 16'd0, 8'd0);
		send_item(OP_DELTA, 16'd0, 16'sd0, 10'd0, 16'd0, 16'd0, KIND_TEMP);
		send_item(OP_ADD, 16'd0, 16'sd100, 10'd1000, 16'd10132, 16'd0, 8'd0);

		// no clears early on so the ring fills and wraps
		for (int n = 0; n < 1900; n++) begin
			calm = (n >= 800 && n < 1100);
			send_random(n >= 700);
		end
		calm = 1'b0;
		in_valid <= 1'b0;

		while (ring.pending_answers.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("%0d items sent: %0d adds stored, %0d reads hit, %0d deltas, %0d clears",
			ring.items_seen, ring.adds_stored, ring.reads_hit, ring.deltas_done,
			ring.clears_done);
		$display("%0d results checked, %0d mismatches", ring.checked, ring.mismatches);
		if (ring.mismatches == 0 && ring.pending_answers.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end
endmodule

[sim.f]
src/hshr_pkg.sv
src/hshr_mem.sv
src/hourly_sample_history_ring.sv
tb/hshr_tb_pkg.sv
tb/tb.sv
